/* rtl/core/gbn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

  localparam int SEQ_SPACE = 16;
  localparam int SEQ_W     = $clog2(SEQ_SPACE);
  localparam int WIDE_W    = SEQ_W + 4;

  localparam int KIND_W  = 2;
  localparam int PORT_SEQ_W = 4;
  localparam int WIN_W   = 4;
  localparam int THR_W   = 3;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 4;

  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DUP_THRESH  = 2'd1;

  localparam logic [WIN_W-1:0] WIN_RESET = 4'd4;
  localparam logic [THR_W-1:0] THR_RESET = 3'd3;

  typedef logic [SEQ_W-1:0] seq_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RETX
  } gbn_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } gbn_cmd_t;

  typedef struct packed {
    logic multi;
    logic rem_one;
  } gbn_sts_t;

  function automatic seq_t seq_inc(input seq_t s);
    seq_t r;
    if (s == seq_t'(SEQ_SPACE - 1)) begin
      r = '0;
    end else begin
      r = s + seq_t'(1);
    end
    return r;
  endfunction

  // modular distance a - b
  function automatic seq_t seq_sub(input seq_t a, input seq_t b);
    logic [SEQ_W:0] w;
    if (a >= b) begin
      w = {1'b0, a} - {1'b0, b};
    end else begin
      w = {1'b0, a} + (SEQ_W+1)'(SEQ_SPACE) - {1'b0, b};
    end
    return w[SEQ_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/go_back_n_sender_window.sv */
// channel  | handshake                     | payload
// in       | start, busy                   | in_kind, in_ack_seq, in_ack_ok
// out      | out_valid (strobe)            | out_accepted .. out_last
// cfg      | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
// a word is taken when start is high and busy low; it is latched into the input
// registers, executed in ST_EXEC, and its first result word is registered into the
// output registers; no new word is taken while busy is high.
// a timeout with n > 1 packets outstanding emits n words on back-to-back cycles;
// busy drops in the cycle of the last word.
// rst_n is synchronous: window state clears, window size 4, threshold 3.
// results are strobed for one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module go_back_n_sender_window (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [gbn_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [gbn_pkg::PORT_SEQ_W-1:0] in_ack_seq,
  input  wire logic                           in_ack_ok,
  output logic                                out_valid,
  output logic                                out_accepted,
  output logic                                out_send_valid,
  output logic [gbn_pkg::PORT_SEQ_W-1:0]      out_send_seq,
  output logic                                out_start_timer,
  output logic                                out_stop_timer,
  output logic                                out_window_empty,
  output logic                                out_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gbn_pkg::CIDX_W-1:0]     cfg_index,
  input  wire logic [gbn_pkg::CDATA_W-1:0]    cfg_data
);

  gbn_pkg::gbn_cmd_t cmd;
  gbn_pkg::gbn_sts_t sts;

  assign cfg_ready = ~busy;

  gbn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  gbn_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_ack_seq       (in_ack_seq),
    .in_ack_ok        (in_ack_ok),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_accepted     (out_accepted),
    .out_send_valid   (out_send_valid),
    .out_send_seq     (out_send_seq),
    .out_start_timer  (out_start_timer),
    .out_stop_timer   (out_stop_timer),
    .out_window_empty (out_window_empty),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

/* rtl/core/gbn_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module gbn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire gbn_pkg::gbn_sts_t sts,
  output gbn_pkg::gbn_cmd_t      cmd,
  output logic                   busy
);

  gbn_pkg::gbn_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbn_pkg::ST_IDLE: begin
        if (start) state_nxt = gbn_pkg::ST_EXEC;
      end
      gbn_pkg::ST_EXEC: begin
        state_nxt = sts.multi ? gbn_pkg::ST_RETX : gbn_pkg::ST_IDLE;
      end
      gbn_pkg::ST_RETX: begin
        if (sts.rem_one) state_nxt = gbn_pkg::ST_IDLE;
      end
      default: state_nxt = gbn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      gbn_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      gbn_pkg::ST_EXEC: cmd.exec = 1'b1;
      gbn_pkg::ST_RETX: cmd.step = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/gbn_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module gbn_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gbn_pkg::gbn_cmd_t                 cmd,
  output gbn_pkg::gbn_sts_t                      sts,
  input  wire logic [gbn_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [gbn_pkg::PORT_SEQ_W-1:0]    in_ack_seq,
  input  wire logic                              in_ack_ok,
  input  wire logic                              cfg_we,
  input  wire logic [gbn_pkg::CIDX_W-1:0]        cfg_index,
  input  wire logic [gbn_pkg::CDATA_W-1:0]       cfg_data,
  output logic                                   out_valid,
  output logic                                   out_accepted,
  output logic                                   out_send_valid,
  output logic [gbn_pkg::PORT_SEQ_W-1:0]         out_send_seq,
  output logic                                   out_start_timer,
  output logic                                   out_stop_timer,
  output logic                                   out_window_empty,
  output logic                                   out_last
);

  localparam int W = gbn_pkg::WIDE_W;

  // latched input word
  logic [gbn_pkg::KIND_W-1:0]     kind_r;
  logic [gbn_pkg::PORT_SEQ_W-1:0] ack_r;
  logic                           ok_r;

  logic [gbn_pkg::WIN_W-1:0] win_r, win_nxt;
  logic [gbn_pkg::THR_W-1:0] thr_r, thr_nxt;
  gbn_pkg::seq_t base_r, base_nxt, next_r, next_nxt, lacked_r, lacked_nxt;
  logic lv_r, lv_nxt;
  logic [gbn_pkg::THR_W-1:0] dup_r, dup_nxt;
  gbn_pkg::seq_t rseq_r, rseq_nxt, rem_r, rem_nxt;

  logic ov_r, ov_nxt;
  logic acc_r, acc_nxt, sv_r, sv_nxt, st_r, st_nxt, sp_r, sp_nxt;
  logic emp_r, emp_nxt, last_r, last_nxt;
  gbn_pkg::seq_t seq_r, seq_nxt;

  gbn_pkg::seq_t outst, ack_s, ack_off, base_ack, after_ack;
  logic [W-1:0] eff, ack_w;
  logic [gbn_pkg::THR_W-1:0] dup_inc;
  logic ack_in, outst_zero;

  always_comb begin
    outst      = gbn_pkg::seq_sub(next_r, base_r);
    outst_zero = (outst == '0);
    eff = (W'(win_r) < W'(gbn_pkg::SEQ_SPACE - 1)) ? W'(win_r) : W'(gbn_pkg::SEQ_SPACE - 1);
    ack_w     = W'(ack_r);
    ack_in    = ack_w < W'(gbn_pkg::SEQ_SPACE);
    ack_s     = ack_w[gbn_pkg::SEQ_W-1:0];
    ack_off   = gbn_pkg::seq_sub(ack_s, base_r);
    base_ack  = gbn_pkg::seq_inc(ack_s);
    after_ack = gbn_pkg::seq_sub(next_r, base_ack);
    dup_inc   = dup_r + 3'd1;
  end

  always_comb begin
    sts.multi   = (kind_r == gbn_pkg::KIND_TIMEOUT) && (outst > gbn_pkg::seq_t'(1));
    sts.rem_one = (rem_r == gbn_pkg::seq_t'(1));
  end

  always_comb begin
    win_nxt    = win_r;
    thr_nxt    = thr_r;
    base_nxt   = base_r;
    next_nxt   = next_r;
    lacked_nxt = lacked_r;
    lv_nxt     = lv_r;
    dup_nxt    = dup_r;
    rseq_nxt   = rseq_r;
    rem_nxt    = rem_r;
    ov_nxt     = 1'b0;
    acc_nxt    = 1'b0;
    sv_nxt     = 1'b0;
    seq_nxt    = '0;
    st_nxt     = 1'b0;
    sp_nxt     = 1'b0;
    emp_nxt    = outst_zero;
    last_nxt   = 1'b1;

    if (cfg_we) begin
      case (cfg_index)
        gbn_pkg::CFG_WINDOW_SIZE: win_nxt = cfg_data;
        gbn_pkg::CFG_DUP_THRESH:  thr_nxt = cfg_data[gbn_pkg::THR_W-1:0];
        default: ;
      endcase
    end

    if (cmd.exec) begin
      ov_nxt = 1'b1;
      case (kind_r)
        gbn_pkg::KIND_DATA: begin
          if (W'(outst) < eff) begin
            acc_nxt  = 1'b1;
            sv_nxt   = 1'b1;
            seq_nxt  = next_r;
            st_nxt   = outst_zero;
            next_nxt = gbn_pkg::seq_inc(next_r);
            emp_nxt  = 1'b0;
          end
        end
        gbn_pkg::KIND_ACK: begin
          if (ok_r && ack_in) begin
            if (lv_r && ack_s == lacked_r) begin
              dup_nxt = dup_inc;
              if (dup_inc == thr_r) begin
                dup_nxt = '0;
                if (!outst_zero) begin
                  sv_nxt  = 1'b1;
                  seq_nxt = base_r;
                  st_nxt  = 1'b1;
                end
              end
            end else if (ack_off < outst) begin
              base_nxt   = base_ack;
              lacked_nxt = ack_s;
              lv_nxt     = 1'b1;
              dup_nxt    = '0;
              sp_nxt     = (after_ack == '0);
              emp_nxt    = (after_ack == '0);
            end
          end
        end
        gbn_pkg::KIND_TIMEOUT: begin
          st_nxt = 1'b1;
          if (!outst_zero) begin
            sv_nxt   = 1'b1;
            seq_nxt  = base_r;
            last_nxt = (outst == gbn_pkg::seq_t'(1));
            rseq_nxt = gbn_pkg::seq_inc(base_r);
            rem_nxt  = outst - gbn_pkg::seq_t'(1);
          end
        end
        default: ;
      endcase
    end

    if (cmd.step) begin
      ov_nxt   = 1'b1;
      sv_nxt   = 1'b1;
      seq_nxt  = rseq_r;
      emp_nxt  = 1'b0;
      last_nxt = sts.rem_one;
      rseq_nxt = gbn_pkg::seq_inc(rseq_r);
      rem_nxt  = rem_r - gbn_pkg::seq_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= gbn_pkg::WIN_RESET;
      thr_r    <= gbn_pkg::THR_RESET;
      base_r   <= '0;
      next_r   <= '0;
      lacked_r <= '0;
      lv_r     <= 1'b0;
      dup_r    <= '0;
      rem_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      win_r    <= win_nxt;
      thr_r    <= thr_nxt;
      base_r   <= base_nxt;
      next_r   <= next_nxt;
      lacked_r <= lacked_nxt;
      lv_r     <= lv_nxt;
      dup_r    <= dup_nxt;
      rem_r    <= rem_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      ack_r  <= in_ack_seq;
      ok_r   <= in_ack_ok;
    end
    rseq_r <= rseq_nxt;
    acc_r  <= acc_nxt;
    sv_r   <= sv_nxt;
    seq_r  <= seq_nxt;
    st_r   <= st_nxt;
    sp_r   <= sp_nxt;
    emp_r  <= emp_nxt;
    last_r <= last_nxt;
  end

  logic [W-1:0] seq_w;
  assign seq_w = W'(seq_r);

  assign out_valid        = ov_r;
  assign out_accepted     = acc_r;
  assign out_send_valid   = sv_r;
  assign out_send_seq     = seq_w[gbn_pkg::PORT_SEQ_W-1:0];
  assign out_start_timer  = st_r;
  assign out_stop_timer   = sp_r;
  assign out_window_empty = emp_r;
  assign out_last         = last_r;

endmodule
`default_nettype wire

/* rtl/core/gbn_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
module gbn_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_accepted,
  input wire logic out_send_valid,
  input wire logic out_window_empty,
  input wire logic out_last
);

  // retransmit burst is continuous
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("retransmit burst broken");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("word taken without going busy");

  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy && out_send_valid && !out_accepted)
    else $error("bad mid-burst word");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("still busy after last word");

  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_send_valid && !out_window_empty)
    else $error("accepted data not sent");

endmodule

bind go_back_n_sender_window gbn_chk u_gbn_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_accepted     (out_accepted),
  .out_send_valid   (out_send_valid),
  .out_window_empty (out_window_empty),
  .out_last         (out_last)
);
`default_nettype wire
